>>> design/cv3_pkg.sv
// Shared types and constants for the streaming 3x3 valid-mode correlator.
package cv3_pkg;

   // Window geometry and field widths
   localparam int KERNEL_SIZE     = 3;
   localparam int COEF_BITS       = 16;
   localparam int KERNEL_ROW_BITS = KERNEL_SIZE * COEF_BITS;
   localparam int SAMPLE_FIELD    = 16;
   localparam int VALUE_BITS      = 35;
   localparam int INDEX_BITS      = 10;
   localparam int DIM_BITS        = 11;
   localparam int DIM_MIN         = 3;
   localparam int DIM_RESET       = 1024;

   // Register map
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_MID    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT  = 3'd4;

   // Input transaction
   typedef struct packed {
      logic signed [SAMPLE_FIELD-1:0] sample;
      logic                           frame_start;
   } cv3_req_type;

   // Result transaction
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] conv_value;
      logic [INDEX_BITS-1:0]        out_row;
      logic [INDEX_BITS-1:0]        out_col;
   } cv3_rsp_type;

   // Position of a result in the output image
   typedef struct packed {
      logic [INDEX_BITS-1:0] out_row;
      logic [INDEX_BITS-1:0] out_col;
   } cv3_pos_type;

   // Kernel rows, row 0 (top) at index 0, column 0 in the low bits of each row
   typedef logic [KERNEL_SIZE-1:0][KERNEL_ROW_BITS-1:0] cv3_kernel_type;

endpackage

>>> design/cv3_csr.sv
// Configuration registers: kernel rows and clamped image dimensions.
module cv3_csr #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cv3_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [cv3_pkg::KERNEL_ROW_BITS-1:0]    csr_data,
   output cv3_pkg::cv3_kernel_type                kernel,
   output logic [$clog2(MAX_WIDTH+1)-1:0]         image_width,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]        image_height
);
   import cv3_pkg::*;

   localparam int WB    = $clog2(MAX_WIDTH+1);
   localparam int HB    = $clog2(MAX_HEIGHT+1);
   localparam int RST_W = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;
   localparam int RST_H = (MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET;

   cv3_kernel_type     kernel_ff, kernel_in;
   logic [WB-1:0]      width_ff, width_in, width_clamp;
   logic [HB-1:0]      height_ff, height_in, height_clamp;
   logic [DIM_BITS-1:0] raw_dim;

   // Dimensions are stored already clamped to the supported range
   always_comb begin
      raw_dim = csr_data[DIM_BITS-1:0];
      if (raw_dim < DIM_BITS'(DIM_MIN)) begin
         width_clamp  = WB'(DIM_MIN);
         height_clamp = HB'(DIM_MIN);
      end else begin
         if (32'(raw_dim) > 32'(MAX_WIDTH)) begin
            width_clamp = WB'(MAX_WIDTH);
         end else begin
            width_clamp = WB'(raw_dim);
         end
         if (32'(raw_dim) > 32'(MAX_HEIGHT)) begin
            height_clamp = HB'(MAX_HEIGHT);
         end else begin
            height_clamp = HB'(raw_dim);
         end
      end
   end

   // Register write decode; unknown indexes are ignored
   always_comb begin
      kernel_in = kernel_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KERNEL_TOP:    kernel_in[0] = csr_data;
            CSR_KERNEL_MID:    kernel_in[1] = csr_data;
            CSR_KERNEL_BOTTOM: kernel_in[2] = csr_data;
            CSR_IMAGE_WIDTH:   width_in     = width_clamp;
            CSR_IMAGE_HEIGHT:  height_in    = height_clamp;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= '0;
         width_ff  <= WB'(RST_W);
         height_ff <= HB'(RST_H);
      end else begin
         kernel_ff <= kernel_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_ready    = 1'b1;
   assign kernel       = kernel_ff;
   assign image_width  = width_ff;
   assign image_height = height_ff;

endmodule

>>> design/cv3_line_buf.sv
// Raster position tracking, two line stores and the 3x3 sample window.
module cv3_line_buf #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  cv3_pkg::cv3_req_type                  req_data,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]        image_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]       image_height,
   output logic                                  win_valid,
   input  logic                                  win_ready,
   output logic [cv3_pkg::KERNEL_SIZE-1:0][cv3_pkg::KERNEL_SIZE-1:0][SAMPLE_BITS-1:0] win_data,
   output cv3_pkg::cv3_pos_type                  win_pos
);
   import cv3_pkg::*;

   localparam int AB = $clog2(MAX_WIDTH);
   localparam int WB = $clog2(MAX_WIDTH+1);
   localparam int HB = $clog2(MAX_HEIGHT+1);

   // Line stores: older holds row r-2, newer holds row r-1
   logic [SAMPLE_BITS-1:0] older_mem [MAX_WIDTH];
   logic [SAMPLE_BITS-1:0] newer_mem [MAX_WIDTH];

   logic [AB-1:0] col_ff, col_in;
   logic [HB-1:0] row_ff, row_in;
   logic          clr_busy_ff, clr_busy_in;
   logic [AB-1:0] clr_addr_ff, clr_addr_in;

   // Stage 1: accepted sample with its line store reads
   logic                   v1_ff, v1_in;
   logic                   emit1_ff;
   logic [SAMPLE_BITS-1:0] x1_ff;
   logic [AB-1:0]          c1_ff;
   cv3_pos_type            pos1_ff;
   logic [SAMPLE_BITS-1:0] older_rd_ff, newer_rd_ff;

   // Stage 2: window
   logic        v2_ff, v2_in;
   logic        emit2_ff;
   cv3_pos_type pos2_ff;
   logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][SAMPLE_BITS-1:0] win_ff;

   logic                   acc, load1, mv1, mv2, free1, free2, fwd;
   logic                   drop, emit, wrap;
   logic [AB-1:0]          c_cur;
   logic [HB-1:0]          r_cur;
   logic [WB-1:0]          col_next;
   cv3_pos_type            pos_cur;
   logic                   wr_en;
   logic [AB-1:0]          wr_addr;
   logic [SAMPLE_BITS-1:0] wr_older, wr_newer;

   // Pipeline flow
   always_comb begin
      mv2       = v2_ff && (!emit2_ff || win_ready);
      free2     = !v2_ff || mv2;
      mv1       = v1_ff && free2;
      free1     = !v1_ff || mv1;
      req_ready = free1 && !clr_busy_ff;
      acc       = req_valid && req_ready;
   end

   // Position of the incoming sample and the counter update
   always_comb begin
      c_cur    = req_data.frame_start ? '0 : col_ff;
      r_cur    = req_data.frame_start ? '0 : row_ff;
      drop     = r_cur >= image_height;
      emit     = (r_cur >= HB'(KERNEL_SIZE-1)) && (c_cur >= AB'(KERNEL_SIZE-1));
      col_next = WB'(c_cur) + WB'(1);
      wrap     = col_next >= image_width;
      load1    = acc && !drop;
      fwd      = mv1 && (c1_ff == c_cur);
      pos_cur.out_row = INDEX_BITS'(r_cur - HB'(KERNEL_SIZE-1));
      pos_cur.out_col = INDEX_BITS'(c_cur - AB'(KERNEL_SIZE-1));
      col_in = col_ff;
      row_in = row_ff;
      if (load1) begin
         if (wrap) begin
            col_in = '0;
            row_in = r_cur + HB'(1);
         end else begin
            col_in = AB'(col_next);
            row_in = r_cur;
         end
      end
   end

   // Clearing sweep after reset, then one row update per item leaving stage 1
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AB'(1);
         if (clr_addr_ff == AB'(MAX_WIDTH-1)) begin
            clr_busy_in = 1'b0;
         end
      end
      wr_en    = clr_busy_ff || mv1;
      wr_addr  = clr_busy_ff ? clr_addr_ff : c1_ff;
      wr_older = clr_busy_ff ? '0 : newer_rd_ff;
      wr_newer = clr_busy_ff ? '0 : x1_ff;
      v1_in    = load1 ? 1'b1 : (mv1 ? 1'b0 : v1_ff);
      v2_in    = mv1 ? 1'b1 : (mv2 ? 1'b0 : v2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
      end
   end

   // Line store write and registered read; the write of the previous
   // sample at the same column is forwarded
   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= wr_older;
         newer_mem[wr_addr] <= wr_newer;
      end
      if (load1) begin
         if (fwd) begin
            older_rd_ff <= newer_rd_ff;
            newer_rd_ff <= x1_ff;
         end else begin
            older_rd_ff <= older_mem[c_cur];
            newer_rd_ff <= newer_mem[c_cur];
         end
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (load1) begin
         x1_ff    <= req_data.sample[SAMPLE_BITS-1:0];
         c1_ff    <= c_cur;
         emit1_ff <= emit;
         pos1_ff  <= pos_cur;
      end
   end

   // Window shift: oldest column out, new column from the line stores and the sample
   always_ff @(posedge clock) begin
      if (mv1) begin
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE-1; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
         end
         win_ff[0][KERNEL_SIZE-1] <= older_rd_ff;
         win_ff[1][KERNEL_SIZE-1] <= newer_rd_ff;
         win_ff[2][KERNEL_SIZE-1] <= x1_ff;
         emit2_ff <= emit1_ff;
         pos2_ff  <= pos1_ff;
      end
   end

   assign win_valid = v2_ff && emit2_ff;
   assign win_data  = win_ff;
   assign win_pos   = pos2_ff;

   // No sample is taken while the line stores are being cleared
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready && !v1_ff && !v2_ff)
      else $error("sample taken during line store clear");

   // A blocked window with stage 1 occupied must stall the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      v1_ff && win_valid && !win_ready |-> !req_ready)
      else $error("input accepted while window stage blocked");

endmodule

>>> design/cv3_mac.sv
// Nine window products, row sums and the final sum into the result register.
module cv3_mac #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  win_valid,
   output logic                                  win_ready,
   input  logic [cv3_pkg::KERNEL_SIZE-1:0][cv3_pkg::KERNEL_SIZE-1:0][SAMPLE_BITS-1:0] win_data,
   input  cv3_pkg::cv3_pos_type                  win_pos,
   input  cv3_pkg::cv3_kernel_type               kernel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output cv3_pkg::cv3_rsp_type                  rsp_data
);
   import cv3_pkg::*;

   localparam int PB = SAMPLE_BITS + COEF_BITS;

   logic signed [PB-1:0]         prod_in [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [PB-1:0]         prod_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [VALUE_BITS-1:0] rsum_in [KERNEL_SIZE];
   logic signed [VALUE_BITS-1:0] rsum_ff [KERNEL_SIZE];
   logic signed [VALUE_BITS-1:0] total;
   cv3_pos_type                  pos3_ff, pos4_ff;
   cv3_rsp_type                  rsp_data_ff;
   logic                         v3_ff, v3_in, v4_ff, v4_in, rsp_valid_ff, rsp_valid_in;
   logic                         ld_out, free4, mv3, free3, load3;

   // Pipeline flow
   always_comb begin
      ld_out       = v4_ff && (!rsp_valid_ff || rsp_ready);
      free4        = !v4_ff || ld_out;
      mv3          = v3_ff && free4;
      free3        = !v3_ff || mv3;
      win_ready    = free3;
      load3        = win_valid && free3;
      v3_in        = load3 ? 1'b1 : (mv3 ? 1'b0 : v3_ff);
      v4_in        = mv3 ? 1'b1 : (ld_out ? 1'b0 : v4_ff);
      rsp_valid_in = ld_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // One signed multiplier per window position
   always_comb begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            prod_in[i][j] = $signed(win_data[i][j]) *
                            $signed(kernel[i][COEF_BITS*j +: COEF_BITS]);
         end
      end
   end

   // Row sums, then the sum of rows
   always_comb begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            rsum_in[i] = rsum_in[i] + VALUE_BITS'(prod_ff[i][j]);
         end
      end
      total = '0;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         total = total + rsum_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         prod_ff <= prod_in;
         pos3_ff <= win_pos;
      end
      if (mv3) begin
         rsum_ff <= rsum_in;
         pos4_ff <= pos3_ff;
      end
      if (ld_out) begin
         rsp_data_ff.conv_value <= total;
         rsp_data_ff.out_row    <= pos4_ff.out_row;
         rsp_data_ff.out_col    <= pos4_ff.out_col;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new result only ever comes from the row-sum stage
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v4_ff))
      else $error("result appeared without a row-sum entry");

   // With every stage full and the output blocked, no window is taken
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      v3_ff && v4_ff && rsp_valid_ff && !rsp_ready |-> !win_ready)
      else $error("window taken while pipeline full");

endmodule

>>> design/conv2d_valid_3x3_stream_top.sv
// Top level of the streaming 3x3 valid-mode 2-D correlator.
// Takes image samples in raster order (frame_start on the first sample of a
// frame) and gives, for every sample that completes a 3x3 window, the
// full-width sum of window times kernel with its row and column in the
// valid output image. A result goes through the stage 1, window, product,
// row-sum and result registers, and the sustained rate is one sample per
// clock when the output is not stalled, set by the single line store write
// and read per column. After reset the two line stores are cleared, during
// which req_ready stays low; configuration writes are taken at all times.
// Samples past the configured height are taken and dropped until the next
// frame start. Width and height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module conv2d_valid_3x3_stream_top #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cv3_pkg::cv3_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cv3_pkg::cv3_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cv3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cv3_pkg::KERNEL_ROW_BITS-1:0] csr_data
);
   import cv3_pkg::*;

   localparam int WB = $clog2(MAX_WIDTH+1);
   localparam int HB = $clog2(MAX_HEIGHT+1);

   cv3_kernel_type kernel;
   logic [WB-1:0]  image_width;
   logic [HB-1:0]  image_height;
   logic           win_valid, win_ready;
   logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][SAMPLE_BITS-1:0] win_data;
   cv3_pos_type    win_pos;

   // Configuration registers
   cv3_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .kernel       (kernel),
      .image_width  (image_width),
      .image_height (image_height)
   );

   // Line stores and window
   cv3_line_buf #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_line_buf (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .image_width  (image_width),
      .image_height (image_height),
      .win_valid    (win_valid),
      .win_ready    (win_ready),
      .win_data     (win_data),
      .win_pos      (win_pos)
   );

   // Multiply-accumulate and result register
   cv3_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .win_valid (win_valid),
      .win_ready (win_ready),
      .win_data  (win_data),
      .win_pos   (win_pos),
      .kernel    (kernel),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/conv2d_valid_3x3_stream_top_test.sv
// Self-checking testbench for the streaming 3x3 valid-mode correlator.
module conv2d_valid_3x3_stream_top_test;
   import cv3_pkg::*;

   localparam int MAX_DIM      = 1024;
   localparam int RANDOM_ITEMS = 620;
   localparam int EDGE_SAMPLES = 48;
   localparam int EDGE_ROWS    = 12;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_REPORTS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] KERNEL_CSR [KERNEL_SIZE] =
      '{CSR_KERNEL_TOP, CSR_KERNEL_MID, CSR_KERNEL_BOTTOM};

   // How the expectation of a directed row is formed
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} check_kind_type;

   // Receiver back-pressure styles
   typedef enum logic [1:0] {RSP_ALWAYS, RSP_MOSTLY, RSP_SELDOM, RSP_PATTERN} ready_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_FIELD-1:0] sample;
      logic                           frame_start;
      check_kind_type                 check;
      logic signed [VALUE_BITS-1:0]   value;
      cv3_pos_type                    pos;
   } directed_row_type;

   // Directed stimulus on a 3x3 image, every coefficient at -32768:
   // a frame cut short mid-row, a full frame at the negative extreme,
   // two samples past the frame, and a full frame at the positive extreme.
   localparam directed_row_type DIRECTED [24] = '{
      '{16'sh0000, 1'b1, CHK_MODEL, '0, '0},
      '{16'sh0001, 1'b0, CHK_MODEL, '0, '0},
      '{16'shffff, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh7fff, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh8000, 1'b1, CHK_MODEL, '0, '0},
      '{16'sh8000, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh8000, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh8000, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh8000, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh8000, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh8000, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh8000, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh8000, 1'b0, CHK_GIVEN, 35'sd9663676416, '{10'd0, 10'd0}},
      '{16'sh1234, 1'b0, CHK_NONE,  '0, '0},
      '{16'shffff, 1'b0, CHK_NONE,  '0, '0},
      '{16'sh7fff, 1'b1, CHK_MODEL, '0, '0},
      '{16'sh7fff, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh7fff, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh7fff, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh7fff, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh7fff, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh7fff, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh7fff, 1'b0, CHK_MODEL, '0, '0},
      '{16'sh7fff, 1'b0, CHK_GIVEN, -35'sd9663381504, '{10'd0, 10'd0}}
   };

   // Clock, reset and block inputs, all known from time zero
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   cv3_req_type                req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   cv3_rsp_type                rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [KERNEL_ROW_BITS-1:0] csr_data = '0;

   // Predictor copy of the registers and the image state
   cv3_kernel_type             kernel_rows = '0;
   logic [DIM_BITS-1:0]        width_reg = 11'(DIM_RESET);
   logic [DIM_BITS-1:0]        height_reg = 11'(DIM_RESET);
   logic signed [SAMPLE_FIELD-1:0] older_line [MAX_DIM] = '{default: '0};
   logic signed [SAMPLE_FIELD-1:0] newer_line [MAX_DIM] = '{default: '0};
   logic signed [SAMPLE_FIELD-1:0] win [KERNEL_SIZE][KERNEL_SIZE] = '{default: '{default: '0}};
   int unsigned                col_pos = 0;
   int unsigned                row_pos = 0;

   cv3_rsp_type                pending_results [$];
   cv3_rsp_type                oldest_result;
   int unsigned                error_count = 0;
   int unsigned                taken_samples = 0;
   int unsigned                burst_left = 0;

   ready_mode_type             ready_mode = RSP_ALWAYS;
   int unsigned                mode_left = 0;
   logic [15:0]                stall_pattern = 16'b1100_1110_0011_0101;

   conv2d_valid_3x3_stream_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Dimensions below 3 act as 3, above the maximum as the maximum
   function automatic int unsigned clamp_dim(input logic [DIM_BITS-1:0] v);
      if (v < DIM_MIN) return DIM_MIN;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   // Advance the image state by one sample; returns 1 when a window completes
   function automatic bit correlate_sample(input cv3_req_type item, output bit used,
                                           output cv3_rsp_type res);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic signed [SAMPLE_FIELD-1:0] up2;
      logic signed [SAMPLE_FIELD-1:0] up1;
      logic signed [COEF_BITS-1:0] k;
      longint acc;
      bit produced;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      used = 1'b0;
      res = '0;
      produced = 1'b0;
      if (item.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      // past the last row: dropped until the next frame start
      if (row_pos >= h) return 1'b0;
      used = 1'b1;
      c = col_pos;
      r = row_pos;
      up2 = older_line[c];
      up1 = newer_line[c];
      for (int i = 0; i < KERNEL_SIZE; i++)
         for (int j = 0; j < KERNEL_SIZE - 1; j++)
            win[i][j] = win[i][j+1];
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = item.sample;
      older_line[c] = up1;
      newer_line[c] = item.sample;
      if (r >= KERNEL_SIZE - 1 && c >= KERNEL_SIZE - 1) begin
         acc = 0;
         for (int i = 0; i < KERNEL_SIZE; i++)
            for (int j = 0; j < KERNEL_SIZE; j++) begin
               k = kernel_rows[i][COEF_BITS*j +: COEF_BITS];
               acc += longint'(win[i][j]) * longint'(k);
            end
         res.conv_value = acc[VALUE_BITS-1:0];
         res.out_row    = INDEX_BITS'(r - (KERNEL_SIZE - 1));
         res.out_col    = INDEX_BITS'(c - (KERNEL_SIZE - 1));
         produced = 1'b1;
      end
      // end of row, also where the width shrank under the current column
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
      end
      return produced;
   endfunction

   // 16-bit word biased towards the extremes and small values
   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 8) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [KERNEL_ROW_BITS-1:0] rand_kernel_row();
      return {rand_word(), rand_word(), rand_word()};
   endfunction

   // Mostly small dimensions, now and then one that is clamped up to 3
   function automatic logic [DIM_BITS-1:0] rand_dim(input int unsigned top);
      if ($urandom_range(0, 9) == 0) return DIM_BITS'($urandom_range(0, 2));
      return DIM_BITS'($urandom_range(DIM_MIN, top));
   endfunction

   task automatic log_mismatch(input string what, input cv3_rsp_type want,
                               input cv3_rsp_type seen);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s: expected value %0d row %0d col %0d, got value %0d row %0d col %0d",
                  $time, what, want.conv_value, want.out_row, want.out_col,
                  seen.conv_value, seen.out_row, seen.out_col);
   endtask

   // One register write, mirrored into the predictor once accepted
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [KERNEL_ROW_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KERNEL_TOP:    kernel_rows[0] = value;
         CSR_KERNEL_MID:    kernel_rows[1] = value;
         CSR_KERNEL_BOTTOM: kernel_rows[2] = value;
         CSR_IMAGE_WIDTH:   width_reg = value[DIM_BITS-1:0];
         CSR_IMAGE_HEIGHT:  height_reg = value[DIM_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sample transaction; sender may idle between bursts of random length
   task automatic offer_sample(input cv3_req_type item);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random samples; a frame start opens the run, or falls at random in noise
   task automatic send_run(input int unsigned count, input bit opens_frame, input bit noisy);
      cv3_req_type item;
      cv3_rsp_type calc;
      bit used;
      for (int unsigned n = 0; n < count; n++) begin
         item.sample      = rand_word();
         item.frame_start = (opens_frame && n == 0) || (noisy && $urandom_range(0, 4) == 0);
         offer_sample(item);
         if (correlate_sample(item, used, calc)) pending_results.push_back(calc);
         if (used) taken_samples++;
      end
   endtask

   // Drop valid and let the pipeline empty before touching the registers
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Receiver back-pressure, switching at random between four styles
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(16, 96);
      end else begin
         mode_left <= mode_left - 1;
      end
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      case (ready_mode)
         RSP_ALWAYS: rsp_ready <= 1'b1;
         RSP_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         RSP_SELDOM: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:    rsp_ready <= stall_pattern[0];
      endcase
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            log_mismatch("result with none expected", '0, rsp_data);
         end else begin
            oldest_result = pending_results.pop_front();
            if (oldest_result.conv_value !== rsp_data.conv_value ||
                oldest_result.out_row !== rsp_data.out_row ||
                oldest_result.out_col !== rsp_data.out_col)
               log_mismatch("wrong result", oldest_result, rsp_data);
         end
      end
   end

   // Stimulus
   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned pick;
      int phase_left;
      cv3_req_type item;
      cv3_rsp_type calc;
      bit used;
      bit got;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on a 3x3 image
      for (int i = 0; i < KERNEL_SIZE; i++) write_csr(KERNEL_CSR[i], 48'h8000_8000_8000);
      write_csr(CSR_IMAGE_WIDTH, 48'd3);
      write_csr(CSR_IMAGE_HEIGHT, 48'd3);
      foreach (DIRECTED[i]) begin
         item.sample      = DIRECTED[i].sample;
         item.frame_start = DIRECTED[i].frame_start;
         offer_sample(item);
         got = correlate_sample(item, used, calc);
         case (DIRECTED[i].check)
            CHK_MODEL: if (got) pending_results.push_back(calc);
            CHK_GIVEN: begin
               calc.conv_value = DIRECTED[i].value;
               calc.out_row    = DIRECTED[i].pos.out_row;
               calc.out_col    = DIRECTED[i].pos.out_col;
               pending_results.push_back(calc);
            end
            default: ;
         endcase
      end

      // Random phases: mostly whole frames, some cut short, some noise;
      // register changes between phases land mid-row and mid-frame
      while (taken_samples < RANDOM_ITEMS) begin
         wait_idle();
         for (int i = 0; i < KERNEL_SIZE; i++)
            if ($urandom_range(0, 2) == 0) write_csr(KERNEL_CSR[i], rand_kernel_row());
         if ($urandom_range(0, 2) == 0) write_csr(CSR_IMAGE_WIDTH, 48'(rand_dim(8)));
         if ($urandom_range(0, 2) == 0) write_csr(CSR_IMAGE_HEIGHT, 48'(rand_dim(6)));
         phase_left = $urandom_range(20, 90);
         while (phase_left > 0) begin
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            pick = $urandom_range(0, 19);
            if (pick < 14) n = w * h;
            else if (pick < 17) n = $urandom_range(1, w * h - 1);
            else n = $urandom_range(1, 12);
            send_run(n, pick < 17, pick >= 17);
            phase_left = phase_left - int'(n);
         end
      end

      // Width past the maximum, height under the minimum: start of one long row
      wait_idle();
      for (int i = 0; i < KERNEL_SIZE; i++) write_csr(KERNEL_CSR[i], rand_kernel_row());
      write_csr(CSR_IMAGE_WIDTH, 48'd2047);
      write_csr(CSR_IMAGE_HEIGHT, 48'd0);
      send_run(EDGE_SAMPLES, 1'b1, 1'b0);

      // Width under the minimum, height at the maximum: the first rows of a tall frame
      wait_idle();
      for (int i = 0; i < KERNEL_SIZE; i++) write_csr(KERNEL_CSR[i], rand_kernel_row());
      write_csr(CSR_IMAGE_WIDTH, 48'd1);
      write_csr(CSR_IMAGE_HEIGHT, 48'd1024);
      send_run(3 * EDGE_ROWS + 2, 1'b1, 1'b0);

      wait_idle();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> sim.f
design/cv3_pkg.sv
design/cv3_csr.sv
design/cv3_line_buf.sv
design/cv3_mac.sv
design/conv2d_valid_3x3_stream_top.sv
tb/conv2d_valid_3x3_stream_top_test.sv
